// File: hw/rtl/ehc_pkg.sv
// shared types, codes and classification function for the header classifier
`timescale 1ns / 1ps
`default_nettype none

package ehc_pkg;

    // frame layout and type constants
    localparam logic [7:0]  ETH_HDR_LEN    = 8'd14;
    localparam logic [7:0]  IPV4_FIXED_END = 8'd34;
    localparam logic [5:0]  IPV4_MIN_HDR   = 6'd20;
    localparam logic [15:0] MIN_ETHERTYPE  = 16'd1536;
    localparam logic [15:0] TYPE_IPV4      = 16'h0800;
    localparam logic [15:0] TYPE_IPV6      = 16'h86DD;
    localparam logic [15:0] TYPE_ARP       = 16'h0806;
    localparam logic [7:0]  PROTO_ZERO     = 8'd0;
    localparam logic [7:0]  PROTO_ICMP     = 8'd1;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [8:0]  UDP_HDR_NEED   = 9'd4;
    localparam logic [8:0]  TCP_HDR_NEED   = 9'd14;
    localparam logic [7:0]  OFFSET_MAX     = 8'd255;

    // frame class codes
    typedef enum logic [3:0] {
        CLS_OTHER_LINK  = 4'd0,
        CLS_IPV6        = 4'd1,
        CLS_ARP         = 4'd2,
        CLS_OTHER_NET   = 4'd3,
        CLS_UDP         = 4'd4,
        CLS_TCP         = 4'd5,
        CLS_ICMP        = 4'd6,
        CLS_OTHER_TRANS = 4'd7,
        CLS_PROTO_ZERO  = 4'd8,
        CLS_TRUNCATED   = 4'd9
    } t_class;

    // captured header fields of one frame
    typedef struct packed {
        logic [15:0] eth_type;
        logic [5:0]  ip_hdr_bytes;
        logic [7:0]  protocol;
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [1:0]  tcp_flags;
        logic [15:0] length;
    } t_hdr;

    // ipv4 header length with short ihl raised to the minimum
    function automatic logic [5:0] eff_hdr(input logic [5:0] ihb);
        eff_hdr = (ihb < IPV4_MIN_HDR) ? IPV4_MIN_HDR : ihb;
    endfunction

    // frame class from captured fields and captured byte count
    function automatic t_class classify(input t_hdr h, input logic [8:0] cnt);
        logic [8:0] l4;
        l4 = {1'b0, ETH_HDR_LEN} + {3'b000, eff_hdr(h.ip_hdr_bytes)};
        if (cnt < {1'b0, ETH_HDR_LEN}) begin
            classify = CLS_TRUNCATED;
        end else if (h.eth_type < MIN_ETHERTYPE) begin
            classify = CLS_OTHER_LINK;
        end else if (h.eth_type == TYPE_IPV6) begin
            classify = CLS_IPV6;
        end else if (h.eth_type == TYPE_ARP) begin
            classify = CLS_ARP;
        end else if (h.eth_type != TYPE_IPV4) begin
            classify = CLS_OTHER_NET;
        end else if (cnt < {1'b0, IPV4_FIXED_END}) begin
            classify = CLS_TRUNCATED;
        end else if (h.protocol == PROTO_ZERO) begin
            classify = CLS_PROTO_ZERO;
        end else if (h.protocol == PROTO_UDP) begin
            classify = (cnt < l4 + UDP_HDR_NEED) ? CLS_TRUNCATED : CLS_UDP;
        end else if (h.protocol == PROTO_TCP) begin
            classify = (cnt < l4 + TCP_HDR_NEED) ? CLS_TRUNCATED : CLS_TCP;
        end else if (h.protocol == PROTO_ICMP) begin
            classify = CLS_ICMP;
        end else begin
            classify = CLS_OTHER_TRANS;
        end
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ethernet_ipv4_header_classifier.sv
// top level of the ethernet / ipv4 header classifier
//
// Takes a captured frame one byte per cycle unless o_in_stall is set, starting
// at the destination MAC, with the wire length on the first byte and last_byte
// set on the final one. One result item is given per frame, for its last byte:
// the class code, MAC addresses, IPv4 addresses, L4 ports, TCP SYN/FIN and the
// wire length. A byte is accepted every cycle unless stalled; it passes an input
// register, then the capture and classification logic writes the result
// register. The byte channel stalls only while a last byte waits in the input
// register behind a result that is still held.
`timescale 1ns / 1ps
`default_nettype none

module ethernet_ipv4_header_classifier (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // byte channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    input  wire logic [15:0] i_wire_length,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [3:0]       o_class_code,
    output logic [47:0]      o_source_mac,
    output logic [47:0]      o_dest_mac,
    output logic [31:0]      o_source_ipv4,
    output logic [31:0]      o_dest_ipv4,
    output logic [15:0]      o_source_port,
    output logic [15:0]      o_dest_port,
    output logic             o_syn_seen,
    output logic             o_fin_seen,
    output logic [15:0]      o_frame_length
);
    import ehc_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic [15:0] r_in_len;
    logic        proc_go;
    logic        in_take;
    logic        res_load;
    t_hdr        hdr;
    logic [8:0]  count;
    t_class      cls;
    logic        ip_ok;
    logic        port_ok;
    logic        is_tcp;

    logic        r_out_valid;
    logic [3:0]  r_class;
    logic [47:0] r_src_mac;
    logic [47:0] r_dst_mac;
    logic [31:0] r_src_ip;
    logic [31:0] r_dst_ip;
    logic [15:0] r_src_port;
    logic [15:0] r_dst_port;
    logic        r_syn;
    logic        r_fin;
    logic [15:0] r_len;

    // flow control: a last byte waits while the result register is held
    assign proc_go    = r_in_valid && !(r_in_last && r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && !proc_go;
    assign in_take    = i_in_valid && !o_in_stall;
    assign res_load   = proc_go && r_in_last;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
            r_in_len  <= i_wire_length;
        end
    end

    ehc_capture u_capture (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (proc_go),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .i_len   (r_in_len),
        .o_hdr   (hdr),
        .o_count (count)
    );

    // classification and field masking
    assign cls     = classify(hdr, count);
    assign ip_ok   = (cls == CLS_UDP) || (cls == CLS_TCP) || (cls == CLS_ICMP)
                  || (cls == CLS_OTHER_TRANS) || (cls == CLS_PROTO_ZERO);
    assign port_ok = (cls == CLS_UDP) || (cls == CLS_TCP);
    assign is_tcp  = (cls == CLS_TCP);

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_class    <= cls;
            r_src_mac  <= hdr.src_mac;
            r_dst_mac  <= hdr.dst_mac;
            r_src_ip   <= ip_ok ? hdr.src_ip : 32'd0;
            r_dst_ip   <= ip_ok ? hdr.dst_ip : 32'd0;
            r_src_port <= port_ok ? hdr.src_port : 16'd0;
            r_dst_port <= port_ok ? hdr.dst_port : 16'd0;
            r_syn      <= is_tcp && hdr.tcp_flags[1];
            r_fin      <= is_tcp && (hdr.tcp_flags == 2'b01);
            r_len      <= hdr.length;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_class_code   = r_class;
    assign o_source_mac   = r_src_mac;
    assign o_dest_mac     = r_dst_mac;
    assign o_source_ipv4  = r_src_ip;
    assign o_dest_ipv4    = r_dst_ip;
    assign o_source_port  = r_src_port;
    assign o_dest_port    = r_dst_port;
    assign o_syn_seen     = r_syn;
    assign o_fin_seen     = r_fin;
    assign o_frame_length = r_len;

endmodule

`default_nettype wire

// File: hw/rtl/ehc_capture.sv
// byte offset tracking and header field capture for one frame at a time
`timescale 1ns / 1ps
`default_nettype none

module ehc_capture (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_last,
    input  wire logic [15:0]   i_len,
    output ehc_pkg::t_hdr      o_hdr,
    output logic [8:0]         o_count
);
    import ehc_pkg::*;

    logic [7:0] r_off;
    logic [7:0] n_off;
    t_hdr       r_hdr;
    t_hdr       n_hdr;
    logic [7:0] l4;
    logic [7:0] rel;

    // fields after this byte, cleared at frame start
    always_comb begin
        n_hdr = r_hdr;
        if (r_off == 8'd0) begin
            n_hdr        = '0;
            n_hdr.length = i_len;
        end
        case (r_off)
            8'd0:  n_hdr.dst_mac[47:40] = i_byte;
            8'd1:  n_hdr.dst_mac[39:32] = i_byte;
            8'd2:  n_hdr.dst_mac[31:24] = i_byte;
            8'd3:  n_hdr.dst_mac[23:16] = i_byte;
            8'd4:  n_hdr.dst_mac[15:8]  = i_byte;
            8'd5:  n_hdr.dst_mac[7:0]   = i_byte;
            8'd6:  n_hdr.src_mac[47:40] = i_byte;
            8'd7:  n_hdr.src_mac[39:32] = i_byte;
            8'd8:  n_hdr.src_mac[31:24] = i_byte;
            8'd9:  n_hdr.src_mac[23:16] = i_byte;
            8'd10: n_hdr.src_mac[15:8]  = i_byte;
            8'd11: n_hdr.src_mac[7:0]   = i_byte;
            8'd12, 8'd13: n_hdr.eth_type = {n_hdr.eth_type[7:0], i_byte};
            8'd14: n_hdr.ip_hdr_bytes = {i_byte[3:0], 2'b00};
            8'd23: n_hdr.protocol = i_byte;
            8'd26, 8'd27, 8'd28, 8'd29: n_hdr.src_ip = {n_hdr.src_ip[23:0], i_byte};
            8'd30, 8'd31, 8'd32, 8'd33: n_hdr.dst_ip = {n_hdr.dst_ip[23:0], i_byte};
            default: ;
        endcase
        // l4 header fields, relative to the end of the ipv4 header
        l4  = ETH_HDR_LEN + {2'b00, eff_hdr(n_hdr.ip_hdr_bytes)};
        rel = r_off - l4;
        if (r_off >= IPV4_FIXED_END && r_off >= l4) begin
            if (rel < 8'd2) begin
                n_hdr.src_port = {n_hdr.src_port[7:0], i_byte};
            end else if (rel < 8'd4) begin
                n_hdr.dst_port = {n_hdr.dst_port[7:0], i_byte};
            end else if (rel == 8'd13) begin
                n_hdr.tcp_flags = i_byte[1:0];
            end
        end
    end

    // offset advances and saturates, last byte restarts the frame
    always_comb begin
        if (i_last) begin
            n_off = 8'd0;
        end else if (r_off == OFFSET_MAX) begin
            n_off = OFFSET_MAX;
        end else begin
            n_off = r_off + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off <= 8'd0;
        end else if (i_en) begin
            r_off <= n_off;
        end
    end

    // captured fields
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr <= '0;
        end else if (i_en) begin
            r_hdr <= n_hdr;
        end
    end

    assign o_hdr   = n_hdr;
    assign o_count = {1'b0, r_off} + 9'd1;

endmodule

`default_nettype wire

// File: hw/rtl/ehc_checker.sv
// port-level checks for the header classifier and their binding
`timescale 1ns / 1ps
`default_nettype none

module ehc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [3:0]  o_class_code,
    input wire logic [31:0] o_source_ipv4,
    input wire logic [15:0] o_source_port,
    input wire logic        o_syn_seen,
    input wire logic        o_fin_seen
);
    import ehc_pkg::*;

    // a held result keeps its class
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_class_code))
        else $error("held result changed");

    // syn and fin never reported together
    a_syn_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_syn_seen && o_fin_seen))
        else $error("syn and fin both set");

    // tcp flags only for tcp frames
    a_flags_tcp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_syn_seen || o_fin_seen) |-> o_class_code == CLS_TCP)
        else $error("tcp flag on non-tcp frame");

    // ports only for udp and tcp frames
    a_port_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_class_code != CLS_UDP && o_class_code != CLS_TCP
        |-> o_source_port == 16'd0)
        else $error("port on non-l4 frame");

    // ipv4 addresses only for ipv4 classes
    a_ip_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_class_code == CLS_OTHER_LINK || o_class_code == CLS_IPV6
        || o_class_code == CLS_ARP || o_class_code == CLS_OTHER_NET
        || o_class_code == CLS_TRUNCATED) |-> o_source_ipv4 == 32'd0)
        else $error("ipv4 address on non-ipv4 frame");

endmodule

bind ethernet_ipv4_header_classifier ehc_checker u_ehc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_class_code  (o_class_code),
    .o_source_ipv4 (o_source_ipv4),
    .o_source_port (o_source_port),
    .o_syn_seen    (o_syn_seen),
    .o_fin_seen    (o_fin_seen)
);

`default_nettype wire
